### hw/rtl/vtkd_pkg.sv
// Shared types, key codes and decode tables for the VT100 key decoder.
// No dependencies; used by vtkd_decoder and vt100_key_decoder_cursor.
package vtkd_pkg;

  // Register reset values and map
  localparam logic [9:0] ROWS_RESET   = 10'd24;
  localparam logic [9:0] COLS_RESET   = 10'd80;
  localparam int unsigned AddrWidth   = 3;
  localparam logic        REG_ROWS    = 1'b0;  // paddr[2] selects the register
  localparam logic        REG_COLS    = 1'b1;

  // Input kinds
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Sequence characters
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CSI   = 8'h5B;  // '['
  localparam logic [7:0] CH_SS3   = 8'h4F;  // 'O'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Key codes
  localparam logic [8:0] KEY_ESC   = 9'd27;
  localparam logic [8:0] KEY_QUIT  = 9'h011;
  localparam logic [8:0] KEY_UP    = 9'd256;
  localparam logic [8:0] KEY_DOWN  = 9'd257;
  localparam logic [8:0] KEY_LEFT  = 9'd258;
  localparam logic [8:0] KEY_RIGHT = 9'd259;
  localparam logic [8:0] KEY_PGUP  = 9'd260;
  localparam logic [8:0] KEY_PGDN  = 9'd261;
  localparam logic [8:0] KEY_HOME  = 9'd262;
  localparam logic [8:0] KEY_END   = 9'd263;
  localparam logic [8:0] KEY_DEL   = 9'd264;

  // Decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_FIRST = 4'b0100,
    PH_DIGIT = 4'b1000
  } phase_e;

  // Decoded key handed from the decoder to the cursor logic
  typedef struct packed {
    logic       emit;
    logic [8:0] code;
  } key_t;

  // One result word
  typedef struct packed {
    logic       quit_request;
    logic [9:0] cursor_row;
    logic [9:0] cursor_col;
    logic [8:0] key_code;
  } result_t;

  // Two-byte sequences: ESC [ x and ESC O x
  function automatic logic [8:0] decode_two(input logic [7:0] first, input logic [7:0] second);
    logic [8:0] k;
    k = KEY_ESC;
    if (first == CH_CSI) begin
      case (second)
        8'h41:   k = KEY_UP;
        8'h42:   k = KEY_DOWN;
        8'h43:   k = KEY_RIGHT;
        8'h44:   k = KEY_LEFT;
        8'h48:   k = KEY_HOME;
        8'h46:   k = KEY_END;
        default: k = KEY_ESC;
      endcase
    end else if (first == CH_SS3) begin
      case (second)
        8'h48:   k = KEY_HOME;
        8'h46:   k = KEY_END;
        default: k = KEY_ESC;
      endcase
    end
    return k;
  endfunction

  // ESC [ digit ~ sequences
  function automatic logic [8:0] decode_digit(input logic [7:0] digit);
    logic [8:0] k;
    case (digit)
      8'h31, 8'h37: k = KEY_HOME;
      8'h33:        k = KEY_DEL;
      8'h34, 8'h38: k = KEY_END;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/vtkd_decoder.sv
// Escape sequence decoder: holds the decode phase and pending sequence bytes.
// Depends on vtkd_pkg for phase, key codes and decode tables.
module vtkd_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          op_i,
  input  logic [7:0]    byte_i,
  output vtkd_pkg::key_t key_o
);

  vtkd_pkg::phase_e phase_q, phase_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       digit_q, digit_d;
  logic             is_digit;

  assign is_digit = (byte_i >= vtkd_pkg::CH_ZERO) && (byte_i <= vtkd_pkg::CH_NINE);

  // Decode the current word against the pending phase
  always_comb begin
    phase_d   = phase_q;
    first_d   = first_q;
    digit_d   = digit_q;
    key_o     = '0;
    if (op_i == vtkd_pkg::OP_TIMEOUT) begin
      // timeout flushes a pending sequence as a plain ESC
      if (phase_q != vtkd_pkg::PH_IDLE) begin
        key_o.emit = 1'b1;
        key_o.code = vtkd_pkg::KEY_ESC;
        phase_d    = vtkd_pkg::PH_IDLE;
      end
    end else begin
      case (phase_q)
        vtkd_pkg::PH_ESC: begin
          first_d = byte_i;
          phase_d = vtkd_pkg::PH_FIRST;
        end
        vtkd_pkg::PH_FIRST: begin
          if (first_q == vtkd_pkg::CH_CSI && is_digit) begin
            digit_d = byte_i;
            phase_d = vtkd_pkg::PH_DIGIT;
          end else begin
            key_o.emit = 1'b1;
            key_o.code = vtkd_pkg::decode_two(first_q, byte_i);
            phase_d    = vtkd_pkg::PH_IDLE;
          end
        end
        vtkd_pkg::PH_DIGIT: begin
          key_o.emit = 1'b1;
          key_o.code = (byte_i == vtkd_pkg::CH_TILDE) ? vtkd_pkg::decode_digit(digit_q)
                                                      : vtkd_pkg::KEY_ESC;
          phase_d    = vtkd_pkg::PH_IDLE;
        end
        default: begin
          if (byte_i == vtkd_pkg::CH_ESC) begin
            phase_d = vtkd_pkg::PH_ESC;
          end else begin
            key_o.emit = 1'b1;
            key_o.code = {1'b0, byte_i};
            phase_d    = vtkd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  // Advance the decode state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= vtkd_pkg::PH_IDLE;
      first_q <= '0;
      digit_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
      digit_q <= digit_d;
    end
  end

endmodule

### hw/rtl/vt100_key_decoder_cursor.sv
// VT100 key decoder with clamped cursor: top level, APB registers, output skid.
// Depends on vtkd_pkg and vtkd_decoder.
//
// Usage: the input stream carries one word per received byte or read-timeout
// tick (tuser = 1 for a timeout). Plain bytes, completed escape sequences and
// timeouts inside a sequence each produce one result word; ESC and the inner
// bytes of a sequence, and a timeout while idle, produce none. A result holds
// the key code, the cursor column and row after the key, and the quit flag.
// The decode and cursor update are combinational, between the input
// handshake and the result register. One word is taken every cycle while the
// receiver keeps up. When the receiver stalls, a second result is caught in a
// skid register and input tready drops until it drains, so nothing is lost.
// Reset clears the decoder to idle, the cursor to column 0 row 0, the screen
// size to 24 rows by 80 columns, and empties both result registers.
// Screen size must be written via APB while the stream is idle (not enforced).
module vt100_key_decoder_cursor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] byte_value
  input  logic        s_axis_tuser_i,  // [0] op
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [8:0] key_code, [18:9] cursor_col,
                                       // [28:19] cursor_row, [29] quit_request
  // register port
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [vtkd_pkg::AddrWidth-1:0] paddr_i,
  input  logic [31:0]                    pwdata_i,
  output logic [31:0]                    prdata_o,
  output logic                           pready_o
);

  logic [9:0]       rows_q, cols_q;
  logic [9:0]       col_q, col_d, row_q, row_d;
  logic [9:0]       max_row, max_col;
  logic [10:0]      row_sum;
  logic             in_fire, cfg_wr, res_valid, out_take;
  vtkd_pkg::key_t   key;
  vtkd_pkg::result_t res, main_q, main_d, skid_q, skid_d;
  logic             main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;

  // Register port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign prdata_o = (paddr_i[2] == vtkd_pkg::REG_COLS) ? {22'd0, cols_q} : {22'd0, rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= vtkd_pkg::ROWS_RESET;
      cols_q <= vtkd_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      if (paddr_i[2] == vtkd_pkg::REG_ROWS) begin
        rows_q <= pwdata_i[9:0];
      end else begin
        cols_q <= pwdata_i[9:0];
      end
    end
  end

  // Input handshake
  assign s_axis_tready_o = ~skid_valid_q;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  vtkd_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .op_i     (s_axis_tuser_i),
    .byte_i   (s_axis_tdata_i),
    .key_o    (key)
  );

  assign res_valid = in_fire & key.emit;

  // Move the cursor for the decoded key, clamped to the screen
  assign max_row = (rows_q == 10'd0) ? 10'd0 : rows_q - 10'd1;
  assign max_col = (cols_q == 10'd0) ? 10'd0 : cols_q - 10'd1;
  assign row_sum = {1'b0, row_q} + {1'b0, rows_q};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    case (key.code)
      vtkd_pkg::KEY_UP:    if (row_q != 10'd0) row_d = row_q - 10'd1;
      vtkd_pkg::KEY_DOWN:  if (row_q < max_row) row_d = row_q + 10'd1;
      vtkd_pkg::KEY_LEFT:  if (col_q != 10'd0) col_d = col_q - 10'd1;
      vtkd_pkg::KEY_RIGHT: if (col_q < max_col) col_d = col_q + 10'd1;
      vtkd_pkg::KEY_PGUP:  row_d = (row_q > rows_q) ? row_q - rows_q : 10'd0;
      vtkd_pkg::KEY_PGDN: begin
        if (row_q < max_row) begin
          row_d = (row_sum > {1'b0, max_row}) ? max_row : row_sum[9:0];
        end
      end
      vtkd_pkg::KEY_HOME:  col_d = 10'd0;
      vtkd_pkg::KEY_END:   col_d = max_col;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (res_valid) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign res.key_code     = key.code;
  assign res.cursor_col   = col_d;
  assign res.cursor_row   = row_d;
  assign res.quit_request = (key.code == vtkd_pkg::KEY_QUIT);

  // Result register with skid: drain main, refill from skid or new word
  assign out_take = main_valid_q & m_axis_tready_i;

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_take) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (main_valid_q && !m_axis_tready_i) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = res;
        main_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = main_valid_q;
  assign m_axis_tdata_o  = {2'b00, main_q};

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds a word while main is empty");

  a_quit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q |-> (main_q.quit_request == (main_q.key_code == vtkd_pkg::KEY_QUIT)))
    else $error("quit flag does not match key code");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q |-> (main_q.key_code <= vtkd_pkg::KEY_DEL))
    else $error("key code out of range");

  a_home_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && main_q.key_code == vtkd_pkg::KEY_HOME) |-> (main_q.cursor_col == 10'd0))
    else $error("home key left column nonzero");

  a_no_result_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready_i) |=> skid_valid_q && $stable(skid_q))
    else $error("skid word lost while receiver stalled");
`endif

endmodule
